// File: hdl/msd_pkg.sv
// package: shared constants, types and state codes for the mean and deviation unit
`timescale 1ns / 1ps
package msd_pkg;
    localparam int MAX_SAMPLES_DEF = 128;
    localparam int SAMPLE_W = 16;
    localparam int TOTAL_W  = 8;
    localparam int Q8_W     = 24;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MEAN,
        ST_PASS,
        ST_VAR,
        ST_ROOT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } unit_ctl_t;
endpackage

// File: hdl/msd_ram.sv
// generic single port synchronous ram with registered read
`timescale 1ns / 1ps
module msd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: hdl/msd_div.sv
// restoring divider, one quotient bit per cycle, signed dividend by unsigned divisor
`timescale 1ns / 1ps
module msd_div #(
    parameter int NW = 64,
    parameter int DW = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  msd_pkg::unit_ctl_t ctl_in,
    input  logic             neg,
    input  logic [NW-1:0]    num,
    input  logic [DW-1:0]    den,
    output logic             busy,
    output logic             done,
    output logic [NW-1:0]    quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg[DW-1:0], q_reg[NW-1]};
        if (ctl_in.start)
        begin
            q_next = num;
            r_next = '0;
            d_next = den;
            neg_next = neg;
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = neg_reg ? (~q_reg + 1'b1) : q_reg;
endmodule

// File: hdl/msd_sqrt.sv
// integer square root, one result bit per cycle
`timescale 1ns / 1ps
module msd_sqrt #(
    parameter int VW = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  msd_pkg::unit_ctl_t ctl_in,
    input  logic [VW-1:0]      val,
    output logic               busy,
    output logic               done,
    output logic [VW/2-1:0]    root
);
    localparam int RW = VW / 2;
    localparam int CW = $clog2(RW + 1);

    logic [VW-1:0] v_reg, v_next;
    logic [RW+1:0] rem_reg, rem_next;
    logic [RW-1:0] rt_reg, rt_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [RW+1:0] trem;
    logic [RW+1:0] tsub;

    always_comb
    begin
        v_next = v_reg;
        rem_next = rem_reg;
        rt_next = rt_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trem = {rem_reg[RW-1:0], v_reg[VW-1:VW-2]};
        tsub = {rt_reg, 2'b01};
        if (ctl_in.start)
        begin
            v_next = val;
            rem_next = '0;
            rt_next = '0;
            cnt_next = CW'(RW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            v_next = {v_reg[VW-3:0], 2'b00};
            if (trem >= tsub)
            begin
                rem_next = trem - tsub;
                rt_next = {rt_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trem;
                rt_next = {rt_reg[RW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        rem_reg <= rem_next;
        rt_reg <= rt_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = rt_reg;
endmodule

// File: hdl/mean_and_std_deviation_unit.sv
// top level: sample store, running sum, mean, deviation pass, divide and square root
`timescale 1ns / 1ps
// Samples are taken one per cycle while busy is low; each is written to the sample
// memory and added to a running sum. A request with last_sample high starts the
// finish: a divide for the mean, a pass over the store reading one entry a cycle
// from the memory port, a second divide for the variance and a square root, all
// with busy high. The result is shown for one cycle with valid high and cannot be
// stalled. Samples beyond MAX_SAMPLES are dropped and reported with status 1.
module mean_and_std_deviation_unit #(
    parameter int MAX_SAMPLES = msd_pkg::MAX_SAMPLES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [msd_pkg::SAMPLE_W-1:0] sample,
    input  logic                             last_sample,
    output logic                             valid,
    output logic [msd_pkg::TOTAL_W-1:0]      sample_total,
    output logic signed [msd_pkg::Q8_W-1:0]  mean_q8,
    output logic [msd_pkg::Q8_W-1:0]         std_dev_q8,
    output logic                             status
);
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = msd_pkg::SAMPLE_W + CW + 1;
    localparam int MW = SW + 8;
    localparam int WW = 64;

    msd_pkg::state_t st_reg, st_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic           ovf_reg, ovf_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic           rv_reg, rv_next;
    logic [WW-1:0]  acc_reg, acc_next;
    logic signed [MW-1:0] mean_reg, mean_next;
    logic signed [MW:0]   diff_reg, diff_next;
    logic           dv_reg, dv_next;
    logic [2*MW+1:0] sq_reg;
    logic           sqv_reg;
    logic           valid_reg, valid_next;
    logic [msd_pkg::Q8_W-1:0] sd_reg, sd_next;

    logic           take;
    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [msd_pkg::SAMPLE_W-1:0] ram_q;
    msd_pkg::unit_ctl_t div_ctl, sq_ctl;
    logic           div_neg;
    logic [WW-1:0]  div_num;
    logic           div_busy, div_done, sq_busy, sq_done;
    logic [WW-1:0]  div_q;
    logic [WW/2-1:0] sq_root;
    logic signed [MW:0] ext_s;
    logic [MW:0]    adiff;
    logic signed [WW-1:0] sum_w;

    assign busy = (st_reg != msd_pkg::ST_LOAD);
    assign take = start && !busy;
    assign ram_we = take && (st_reg == msd_pkg::ST_LOAD) && (cnt_reg < CW'(MAX_SAMPLES));
    assign ram_addr = (st_reg == msd_pkg::ST_PASS) ? idx_reg[AW-1:0] : cnt_reg[AW-1:0];

    msd_ram #(.WIDTH(msd_pkg::SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(sample), .rdata(ram_q)
    );

    assign sum_w = WW'(sum_reg) <<< 8;
    assign ext_s = (MW+1)'($signed(ram_q)) <<< 8;
    assign adiff = diff_reg[MW] ? (MW+1)'(-diff_reg) : (MW+1)'(diff_reg);

    always_comb
    begin
        div_ctl.busy = div_busy;
        div_ctl.start = 1'b0;
        div_neg = 1'b0;
        div_num = acc_reg;
        sq_ctl.busy = sq_busy;
        sq_ctl.start = 1'b0;
        st_next = st_reg;
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        ovf_next = ovf_reg;
        idx_next = idx_reg;
        rv_next = 1'b0;
        acc_next = acc_reg;
        mean_next = mean_reg;
        diff_next = diff_reg;
        dv_next = 1'b0;
        valid_next = 1'b0;
        sd_next = sd_reg;
        case (st_reg)
            msd_pkg::ST_LOAD:
            begin
                if (take)
                begin
                    if (cnt_reg < CW'(MAX_SAMPLES))
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        sum_next = sum_reg + SW'(sample);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_sample)
                    begin
                        st_next = msd_pkg::ST_MEAN;
                    end
                end
            end
            msd_pkg::ST_MEAN:
            begin
                if (!div_busy && !div_done)
                begin
                    div_ctl.start = 1'b1;
                    div_neg = sum_reg[SW-1];
                    div_num = sum_reg[SW-1] ? WW'(-sum_w) : WW'(sum_w);
                end
                else if (div_done)
                begin
                    mean_next = MW'(div_q);
                    idx_next = '0;
                    acc_next = '0;
                    st_next = msd_pkg::ST_PASS;
                end
            end
            msd_pkg::ST_PASS:
            begin
                if (idx_reg < cnt_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                    rv_next = 1'b1;
                end
                else if (!rv_reg && !dv_reg && !sqv_reg)
                begin
                    st_next = msd_pkg::ST_VAR;
                end
                if (rv_reg)
                begin
                    diff_next = ext_s - (MW+1)'(mean_reg);
                    dv_next = 1'b1;
                end
                if (sqv_reg)
                begin
                    acc_next = acc_reg + WW'(sq_reg);
                end
            end
            msd_pkg::ST_VAR:
            begin
                if (!div_busy && !div_done)
                begin
                    div_ctl.start = 1'b1;
                end
                else if (div_done)
                begin
                    sq_ctl.start = 1'b1;
                    st_next = msd_pkg::ST_ROOT;
                end
            end
            msd_pkg::ST_ROOT:
            begin
                if (sq_done)
                begin
                    sd_next = msd_pkg::Q8_W'(sq_root);
                    valid_next = 1'b1;
                    st_next = msd_pkg::ST_DONE;
                end
            end
            msd_pkg::ST_DONE:
            begin
                cnt_next = '0;
                sum_next = '0;
                ovf_next = 1'b0;
                st_next = msd_pkg::ST_LOAD;
            end
            default:
            begin
                st_next = msd_pkg::ST_LOAD;
            end
        endcase
    end

    msd_div #(.NW(WW), .DW(CW)) u_div (
        .clk(clk), .rst_n(rst_n), .ctl_in(div_ctl), .neg(div_neg), .num(div_num),
        .den(cnt_reg), .busy(div_busy), .done(div_done), .quo(div_q)
    );

    msd_sqrt #(.VW(WW)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .ctl_in(sq_ctl), .val(div_q),
        .busy(sq_busy), .done(sq_done), .root(sq_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= msd_pkg::ST_LOAD;
            cnt_reg <= '0;
            sum_reg <= '0;
            ovf_reg <= 1'b0;
            rv_reg <= 1'b0;
            dv_reg <= 1'b0;
            sqv_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
            ovf_reg <= ovf_next;
            rv_reg <= rv_next;
            dv_reg <= dv_next;
            sqv_reg <= dv_reg;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        acc_reg <= acc_next;
        mean_reg <= mean_next;
        diff_reg <= diff_next;
        sq_reg <= (2*MW+2)'(adiff) * (2*MW+2)'(adiff);
        sd_reg <= sd_next;
    end

    assign valid = valid_reg;
    assign sample_total = msd_pkg::TOTAL_W'(cnt_reg);
    assign mean_q8 = msd_pkg::Q8_W'(mean_reg);
    assign std_dev_q8 = sd_reg;
    assign status = ovf_reg;
endmodule

// File: hdl/msd_checker.sv
// port level checks for the mean and deviation unit, bound to the top level
`timescale 1ns / 1ps
module msd_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_sample,
    input logic valid
);
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_sample |=> busy)
        else $error("busy not raised after last request");
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy)
        else $error("result outside finish");
    a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("result longer than one cycle");
    a_valid_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !busy)
        else $error("busy held after result");
endmodule

bind mean_and_std_deviation_unit msd_checker u_msd_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .last_sample(last_sample), .valid(valid)
);

// File: tb/tb.sv
// testbench: mean and deviation unit checked against a behavioral predictor
`timescale 1ns / 1ps
module tb;
    localparam int DEPTH = msd_pkg::MAX_SAMPLES_DEF;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        logic [msd_pkg::TOTAL_W-1:0]     total;
        logic signed [msd_pkg::Q8_W-1:0] mean;
        logic [msd_pkg::Q8_W-1:0]        dev;
        logic                            ovf;
    } stats_t;

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    logic signed [msd_pkg::SAMPLE_W-1:0] sample;
    logic                                last_sample;
    logic                                valid;
    logic [msd_pkg::TOTAL_W-1:0]         sample_total;
    logic signed [msd_pkg::Q8_W-1:0]     mean_q8;
    logic [msd_pkg::Q8_W-1:0]            std_dev_q8;
    logic                                status;

    // predictor state
    logic signed [msd_pkg::SAMPLE_W-1:0] set_mem [DEPTH];
    int                                  set_count;
    longint                              set_sum;
    bit                                  set_dropped;
    stats_t                              stats_q[$];

    int fails = 0;
    int requests;
    int sets_done;
    int overflow_sets;
    int burst_left;
    int idle_cycles = 0;

    mean_and_std_deviation_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample(sample), .last_sample(last_sample), .valid(valid),
        .sample_total(sample_total), .mean_q8(mean_q8),
        .std_dev_q8(std_dev_q8), .status(status)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    task automatic predict_stats(logic signed [msd_pkg::SAMPLE_W-1:0] s, logic l);
        stats_t          e;
        longint          m;
        longint          d;
        longint unsigned acc;
        if (set_count < DEPTH)
        begin
            set_mem[set_count] = s;
            set_count++;
            set_sum += s;
        end
        else
            set_dropped = 1;
        if (!l)
            return;
        m = (set_sum * 256) / longint'(set_count);
        acc = 0;
        for (int i = 0; i < set_count; i++)
        begin
            d = longint'(set_mem[i]) * 256 - m;
            if (d < 0)
                d = -d;
            acc += longint'(d) * longint'(d);
        end
        e.total = set_count[msd_pkg::TOTAL_W-1:0];
        e.mean = m[msd_pkg::Q8_W-1:0];
        e.dev = msd_pkg::Q8_W'(floor_root(acc / longint'(set_count)));
        e.ovf = set_dropped;
        if (set_dropped)
            overflow_sets++;
        sets_done++;
        stats_q.push_back(e);
        set_count = 0;
        set_sum = 0;
        set_dropped = 0;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fails++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        stats_t e;
        if (rst_n && valid)
        begin
            idle_cycles <= 0;
            if (stats_q.size() == 0)
                report_mismatch("unexpected result, total", sample_total, 0);
            else
            begin
                e = stats_q.pop_front();
                if (sample_total !== e.total)
                    report_mismatch("sample_total", sample_total, e.total);
                if (mean_q8 !== e.mean)
                    report_mismatch("mean_q8", mean_q8, e.mean);
                if (std_dev_q8 !== e.dev)
                    report_mismatch("std_dev_q8", std_dev_q8, e.dev);
                if (status !== e.ovf)
                    report_mismatch("status", status, e.ovf);
            end
        end
        else if (rst_n && start && !busy)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // watchdog
    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic send_request(logic signed [msd_pkg::SAMPLE_W-1:0] s, logic l);
        start <= 1'b1;
        sample <= s;
        last_sample <= l;
        do
            @(posedge clk);
        while (busy);
        requests++;
        predict_stats(s, l);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 8);
        end
        else
            burst_left--;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (stats_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic logic signed [msd_pkg::SAMPLE_W-1:0] rand_sample(int kind);
        case (kind)
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return msd_pkg::SAMPLE_W'($urandom_range(0, 20) - 10);
            3: return msd_pkg::SAMPLE_W'($urandom_range(0, 2000) + 30000);
            default: return msd_pkg::SAMPLE_W'($urandom());
        endcase
    endfunction

    task automatic send_set(int n, int kind);
        for (int i = 0; i < n; i++)
            send_request(rand_sample(kind == 5 ? $urandom_range(0, 4) : kind), i == n - 1);
    endtask

    task automatic test_extremes();
        send_request(16'sh7fff, 1);
        send_request(16'sh8000, 1);
        send_request(16'sh7fff, 0);
        send_request(16'sh8000, 1);
        send_request(0, 1);
        // negative mean truncates toward zero
        send_request(-1, 0);
        send_request(0, 0);
        send_request(0, 1);
        send_request(1, 0);
        send_request(0, 0);
        send_request(0, 1);
        for (int i = 0; i < 4; i++)
            send_request(-1234, i == 3);
        send_request(16'sh8000, 0);
        send_request(16'sh8000, 0);
        send_request(16'sh7fff, 1);
    endtask

    task automatic test_full_and_overflow();
        send_set(DEPTH, 0);
        send_set(DEPTH + 1, 1);
        send_set(DEPTH + 5, 5);
        wait_drained();
    endtask

    task automatic test_random_sets();
        int n;
        while (requests < 1650)
        begin
            if ($urandom_range(0, 14) == 0)
                n = $urandom_range(DEPTH - 2, DEPTH + 6);
            else
                n = $urandom_range(1, 24);
            send_set(n, $urandom_range(0, 9) < 3 ? $urandom_range(0, 3) : 5);
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        start = 0;
        sample = 0;
        last_sample = 0;
        requests = 0;
        sets_done = 0;
        overflow_sets = 0;
        burst_left = 0;
        set_count = 0;
        set_sum = 0;
        set_dropped = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        wait_drained();
        test_full_and_overflow();
        test_random_sets();
        wait_drained();
        repeat (300) @(posedge clk);
        $display("covered %0d requests in %0d sets, %0d of them over capacity",
                 requests, sets_done, overflow_sets);
        if (fails == 0 && stats_q.size() == 0)
            $display("tb OK");
        else
        begin
            $display("%0d mismatches, %0d results missing", fails, stats_q.size());
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

// File: files.f
hdl/msd_pkg.sv
hdl/msd_ram.sv
hdl/msd_div.sv
hdl/msd_sqrt.sv
hdl/mean_and_std_deviation_unit.sv
hdl/msd_checker.sv
tb/tb.sv
